// ----- rtl/core/jdtf_pkg.sv -----
// shared types, constants and popcount for the jaccard distance filter
package jdtf_pkg;

  localparam int WORD_W      = 64;
  localparam int INDEX_WIDTH = 20;
  localparam int DIST_W      = 17;
  localparam int FRAC_BITS   = 16;
  localparam int POP_W       = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 17;

  localparam int FINGERPRINT_BITS_DEFAULT = 512;
  localparam int QUEUE_DEPTH_DEFAULT      = 2;

  localparam logic [DIST_W-1:0] THRESHOLD_RESET = 17'h10000;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXCLUDE   = 1'd1;

  typedef struct packed {
    logic [WORD_W-1:0]      query_word;
    logic [WORD_W-1:0]      ref_word;
    logic                   last_word;
    logic [INDEX_WIDTH-1:0] query_index;
    logic [INDEX_WIDTH-1:0] ref_index;
  } item_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] match_query_index;
    logic [INDEX_WIDTH-1:0] match_ref_index;
    logic [DIST_W-1:0]      distance;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_OUTPUT
  } back_state_t;

  function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] w);
    logic [POP_W-1:0] c;
    c = '0;
    for (int i = 0; i < WORD_W; i++) begin
      c = c + POP_W'(w[i]);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/jdtf_front.sv -----
// front end: popcount accumulation per fingerprint pair and index exclusion
module jdtf_front import jdtf_pkg::*; #(
  parameter int FINGERPRINT_BITS = FINGERPRINT_BITS_DEFAULT,
  parameter int CW = $clog2(FINGERPRINT_BITS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  item_t                  item,
  input  logic                   exclude_same_index,
  output logic                   push,
  output logic [CW-1:0]          and_count,
  output logic [CW-1:0]          or_count,
  output logic [INDEX_WIDTH-1:0] query_index,
  output logic [INDEX_WIDTH-1:0] ref_index
);

  localparam logic [CW:0] SAT_MAX = (CW + 1)'(FINGERPRINT_BITS);

  logic [CW-1:0] intersection_count;
  logic [CW-1:0] union_count;
  logic [CW:0]   and_sum;
  logic [CW:0]   or_sum;

  always_comb begin
    and_sum = {1'b0, intersection_count} +
              (CW + 1)'(pop64(item.query_word & item.ref_word));
    or_sum  = {1'b0, union_count} +
              (CW + 1)'(pop64(item.query_word | item.ref_word));
    and_count = (and_sum > SAT_MAX) ? SAT_MAX[CW-1:0] : and_sum[CW-1:0];
    or_count  = (or_sum > SAT_MAX) ? SAT_MAX[CW-1:0] : or_sum[CW-1:0];
    query_index = item.query_index;
    ref_index   = item.ref_index;
    push = accept && item.last_word &&
           !(exclude_same_index && (item.query_index == item.ref_index));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      intersection_count <= '0;
      union_count        <= '0;
    end else if (accept) begin
      if (item.last_word) begin
        intersection_count <= '0;
        union_count        <= '0;
      end else begin
        intersection_count <= and_count;
        union_count        <= or_count;
      end
    end
  end

endmodule

// ----- rtl/core/jdtf_queue.sv -----
// short fifo between front and back ends
module jdtf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW:0] DEPTH_C = (AW + 1)'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      fill;

  assign full     = (fill == DEPTH_C);
  assign empty    = (fill == '0);
  assign pop_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      fill <= fill + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

endmodule

// ----- rtl/core/jdtf_back.sv -----
// back end: bit-serial distance division, threshold test and result register
module jdtf_back import jdtf_pkg::*; #(
  parameter int FINGERPRINT_BITS = FINGERPRINT_BITS_DEFAULT,
  parameter int CW = $clog2(FINGERPRINT_BITS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  logic [CW-1:0]          q_and_count,
  input  logic [CW-1:0]          q_or_count,
  input  logic [INDEX_WIDTH-1:0] q_query_index,
  input  logic [INDEX_WIDTH-1:0] q_ref_index,
  output logic                   pop,
  input  logic [DIST_W-1:0]      distance_threshold,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result
);

  localparam int STEP_W = $clog2(DIST_W);
  localparam int PROD_W = DIST_W + CW;

  back_state_t state;
  back_state_t state_next;

  logic [CW-1:0]          divisor;
  logic [CW-1:0]          numer;
  logic [CW:0]            rem;
  logic [DIST_W-1:0]      quot;
  logic [STEP_W-1:0]      step;
  logic [INDEX_WIDTH-1:0] qi;
  logic [INDEX_WIDTH-1:0] ri;

  logic              q_bit;
  logic [CW:0]       rem_sub;
  logic [PROD_W-1:0] limit;
  logic [PROD_W-1:0] scaled_diff;
  logic              pass;
  logic              last_step;

  always_comb begin
    q_bit       = (rem >= {1'b0, divisor});
    rem_sub     = q_bit ? (rem - {1'b0, divisor}) : rem;
    limit       = PROD_W'(distance_threshold) * PROD_W'(divisor);
    scaled_diff = PROD_W'({numer, {FRAC_BITS{1'b0}}});
    pass        = (scaled_diff <= limit);
    last_step   = (step == '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) state_next = BK_DIVIDE;
      end
      BK_DIVIDE: begin
        if (last_step) state_next = pass ? BK_OUTPUT : BK_IDLE;
      end
      BK_OUTPUT: begin
        if (result_ready) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop          = (state == BK_IDLE) && !q_empty;
    result_valid = (state == BK_OUTPUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      divisor <= q_or_count;
      numer   <= q_or_count - q_and_count;
      rem     <= {1'b0, q_or_count - q_and_count};
      quot    <= '0;
      step    <= STEP_W'(DIST_W - 1);
      qi      <= q_query_index;
      ri      <= q_ref_index;
    end else if (state == BK_DIVIDE) begin
      rem  <= {rem_sub[CW-1:0], 1'b0};
      quot <= {quot[DIST_W-2:0], q_bit};
      step <= step - 1'b1;
      if (last_step) begin
        result.match_query_index <= qi;
        result.match_ref_index   <= ri;
        result.distance <= (divisor == '0) ? '0 : {quot[DIST_W-2:0], q_bit};
      end
    end
  end

endmodule

// ----- rtl/core/jaccard_distance_threshold_filter_top.sv -----
// top level of the jaccard distance threshold filter
//
//  channel | direction | handshake               | payload
//  item    | in        | item_valid/item_ready   | item_t, one fingerprint word pair
//  result  | out       | result_valid/result_ready | result_t, one accepted pair
//  cfg     | in        | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// one word pair taken per cycle while the pair queue has room
// each pair is loaded by the idle back end, then runs the bit-serial divider,
// and a pair within the threshold is held in the output register until taken
// item_ready drops while the queue is full; the front stalls only then
// synchronous reset clears counts, queue, back end state; config gets defaults
module jaccard_distance_threshold_filter_top import jdtf_pkg::*; #(
  parameter int FINGERPRINT_BITS = FINGERPRINT_BITS_DEFAULT,
  parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(FINGERPRINT_BITS + 1);
  localparam int QW = 2 * CW + 2 * INDEX_WIDTH;

  logic [DIST_W-1:0] distance_threshold;
  logic              exclude_same_index;

  logic                   accept;
  logic                   push;
  logic                   pop;
  logic                   q_full;
  logic                   q_empty;
  logic [CW-1:0]          f_and;
  logic [CW-1:0]          f_or;
  logic [INDEX_WIDTH-1:0] f_qi;
  logic [INDEX_WIDTH-1:0] f_ri;
  logic [QW-1:0]          q_out;

  assign cfg_ready  = 1'b1;
  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_threshold <= THRESHOLD_RESET;
      exclude_same_index <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THRESHOLD: distance_threshold <= cfg_data[DIST_W-1:0];
        CFG_EXCLUDE:   exclude_same_index <= cfg_data[0];
        default: ;
      endcase
    end
  end

  jdtf_front #(
    .FINGERPRINT_BITS(FINGERPRINT_BITS),
    .CW(CW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .item(item),
    .exclude_same_index(exclude_same_index),
    .push(push),
    .and_count(f_and),
    .or_count(f_or),
    .query_index(f_qi),
    .ref_index(f_ri)
  );

  jdtf_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data({f_and, f_or, f_qi, f_ri}),
    .pop(pop),
    .pop_data(q_out),
    .full(q_full),
    .empty(q_empty)
  );

  jdtf_back #(
    .FINGERPRINT_BITS(FINGERPRINT_BITS),
    .CW(CW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_and_count(q_out[QW-1 -: CW]),
    .q_or_count(q_out[QW-CW-1 -: CW]),
    .q_query_index(q_out[2*INDEX_WIDTH-1 -: INDEX_WIDTH]),
    .q_ref_index(q_out[INDEX_WIDTH-1:0]),
    .pop(pop),
    .distance_threshold(distance_threshold),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

endmodule

// ----- rtl/core/jdtf_checker.sv -----
// port-level checks for the jaccard distance filter, bound to the top level
module jdtf_checker import jdtf_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result,
  input logic    cfg_ready
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result transaction dropped or changed while stalled");

  a_distance_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.distance <= THRESHOLD_RESET)
    else $error("distance above one");

  a_reset_quiet: assert property (@(posedge clk)
    $fell(rst) |-> !result_valid && item_ready)
    else $error("outputs not quiet after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind jaccard_distance_threshold_filter_top jdtf_checker u_checker (
  .clk(clk),
  .rst(rst),
  .item_ready(item_ready),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result(result),
  .cfg_ready(cfg_ready)
);

// ----- sim/jdtf_match_checker.sv -----
// checker for the jaccard distance filter: predicts accepted pairs and compares results
module jdtf_match_checker import jdtf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   item_ready,
  input  item_t                  item,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  result_t                result,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int unsigned            errors,
  output int unsigned            outstanding
);

  localparam int COUNT_W = 10;

  logic [COUNT_W-1:0] and_acc;
  logic [COUNT_W-1:0] or_acc;
  logic [DIST_W-1:0]  threshold_q16;
  logic               drop_same_index;
  result_t            expected_matches[$];

  function automatic logic [COUNT_W-1:0] saturating_add(input logic [COUNT_W-1:0] acc,
                                                        input int unsigned add);
    int unsigned sum;
    sum = acc + add;
    if (sum > FINGERPRINT_BITS_DEFAULT) begin
      sum = FINGERPRINT_BITS_DEFAULT;
    end
    return COUNT_W'(sum);
  endfunction

  always @(posedge clk) begin
    result_t     want;
    logic [63:0] scaled_gap;
    logic        keep;
    if (rst) begin
      and_acc         = '0;
      or_acc          = '0;
      threshold_q16   = THRESHOLD_RESET;
      drop_same_index = 1'b1;
      expected_matches.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_THRESHOLD) begin
          threshold_q16 = cfg_data;
        end else if (cfg_index == CFG_EXCLUDE) begin
          drop_same_index = cfg_data[0];
        end
      end
      if (item_valid && item_ready) begin
        and_acc = saturating_add(and_acc, $countones(item.query_word & item.ref_word));
        or_acc  = saturating_add(or_acc, $countones(item.query_word | item.ref_word));
        if (item.last_word) begin
          scaled_gap = 64'(or_acc - and_acc) << FRAC_BITS;
          keep = scaled_gap <= 64'(threshold_q16) * 64'(or_acc);
          if (drop_same_index && item.query_index == item.ref_index) begin
            keep = 1'b0;
          end
          want.match_query_index = item.query_index;
          want.match_ref_index   = item.ref_index;
          want.distance = (or_acc == '0) ? '0 : DIST_W'(scaled_gap / 64'(or_acc));
          if (keep) begin
            expected_matches.insert(expected_matches.size(), want);
          end
          and_acc = '0;
          or_acc  = '0;
        end
      end
      if (result_valid && result_ready) begin
        if (expected_matches.size() == 0) begin
          $error("unexpected result transaction: query %0d ref %0d distance %0d",
                 result.match_query_index, result.match_ref_index, result.distance);
          errors <= errors + 1;
        end else begin
          want = expected_matches.pop_front();
          if (result.match_query_index !== want.match_query_index) begin
            $error("match_query_index: expected %0d, got %0d",
                   want.match_query_index, result.match_query_index);
          end
          if (result.match_ref_index !== want.match_ref_index) begin
            $error("match_ref_index: expected %0d, got %0d",
                   want.match_ref_index, result.match_ref_index);
          end
          if (result.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, result.distance);
          end
          if (result !== want) begin
            errors <= errors + 1;
          end
        end
      end
    end
    outstanding <= expected_matches.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// testbench top for the jaccard distance filter: stimulus, idling and verdict
module tb_top;
  import jdtf_pkg::*;

  localparam int unsigned LIMIT  = 500_000;
  localparam int unsigned SETTLE = 80;

  typedef enum int {
    FP_RANDOM,
    FP_NEAR,
    FP_SUBSET,
    FP_EQUAL,
    FP_DISJOINT,
    FP_LOPSIDED,
    FP_EMPTY,
    FP_FULL
  } fp_kind_t;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   item_valid   = 1'b0;
  item_t                  item         = '0;
  logic                   result_ready = 1'b0;
  logic                   cfg_valid    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   item_ready;
  logic                   result_valid;
  result_t                result;
  logic                   cfg_ready;
  int unsigned            errors;
  int unsigned            outstanding;
  int unsigned            cycles     = 0;
  int unsigned            words_sent = 0;
  int unsigned            hold_left  = 0;
  bit                     calm       = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  jaccard_distance_threshold_filter_top DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  jdtf_match_checker match_chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stalls in random bursts, and stays ready while calm
  always @(negedge clk) begin
    if (calm) begin
      result_ready <= 1'b1;
      hold_left = 0;
    end else if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      result_ready <= 1'b0;
      hold_left = $urandom_range(0, 11);
    end else begin
      result_ready <= 1'b1;
    end
  end

  task automatic push_word(input item_t w);
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic pause_items(input int unsigned n);
    item_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_for_matches();
    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [DIST_W-1:0] thr, input logic excl);
    wait_for_matches();
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_EXCLUDE, {16'($urandom), excl});
  endtask

  task automatic send_pair(input int unsigned nwords, input fp_kind_t kind,
                           input logic [INDEX_WIDTH-1:0] qi,
                           input logic [INDEX_WIDTH-1:0] ri);
    item_t       w;
    logic [63:0] q;
    logic [63:0] r;
    for (int unsigned k = 0; k < nwords; k++) begin
      q = {$urandom, $urandom};
      r = {$urandom, $urandom};
      case (kind)
        FP_NEAR: begin
          r = q ^ (64'd1 << $urandom_range(0, 63))
                ^ (64'($urandom_range(0, 1)) << $urandom_range(0, 63));
        end
        FP_SUBSET: r = q & r;
        FP_EQUAL: r = q;
        FP_DISJOINT: r = ~q;
        FP_LOPSIDED: begin
          q = '1;
          r = '0;
        end
        FP_EMPTY: begin
          q = '0;
          r = '0;
        end
        FP_FULL: begin
          q = '1;
          r = '1;
        end
        default: ;
      endcase
      w.query_word  = q;
      w.ref_word    = r;
      w.last_word   = (k == nwords - 1);
      w.query_index = w.last_word ? qi : INDEX_WIDTH'($urandom);
      w.ref_index   = w.last_word ? ri : INDEX_WIDTH'($urandom);
      if (!calm && $urandom_range(0, 9) == 0) begin
        pause_items($urandom_range(1, 12));
      end
      push_word(w);
    end
  endtask

  task automatic send_random_pair();
    int unsigned              pick;
    int unsigned              nwords;
    fp_kind_t                 kind;
    logic [INDEX_WIDTH-1:0]   qi;
    logic [INDEX_WIDTH-1:0]   ri;
    pick = $urandom_range(0, 99);
    if (pick < 35)      kind = FP_RANDOM;
    else if (pick < 58) kind = FP_NEAR;
    else if (pick < 68) kind = FP_SUBSET;
    else if (pick < 76) kind = FP_EQUAL;
    else if (pick < 83) kind = FP_DISJOINT;
    else if (pick < 87) kind = FP_LOPSIDED;
    else if (pick < 94) kind = FP_EMPTY;
    else                kind = FP_FULL;
    pick = $urandom_range(0, 9);
    if (pick < 6)      nwords = 8;
    else if (pick < 8) nwords = $urandom_range(1, 7);
    else               nwords = $urandom_range(9, 12);
    qi = INDEX_WIDTH'($urandom);
    ri = INDEX_WIDTH'($urandom);
    pick = $urandom_range(0, 19);
    if (pick < 4)       ri = qi;
    else if (pick == 4) qi = '0;
    else if (pick == 5) ri = '1;
    send_pair(nwords, kind, qi, ri);
  endtask

  initial begin
    int unsigned       target;
    logic [DIST_W-1:0] thr;
    logic              excl;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: distance up to 1.0, same index dropped
    send_pair(1, FP_EMPTY, 20'h00000, 20'hFFFFF);
    send_pair(2, FP_EQUAL, 20'hFFFFF, 20'h00000);
    send_pair(2, FP_DISJOINT, 20'h12345, 20'h54321);
    send_pair(1, FP_LOPSIDED, 20'h00010, 20'h00020);
    send_pair(1, FP_RANDOM, 20'h0ABCD, 20'h0ABCD);
    send_pair(9, FP_FULL, 20'h00001, 20'h00002);
    send_pair(2, FP_NEAR, 20'h00003, 20'h00004);

    configure(17'd0, 1'b0);
    send_pair(1, FP_EQUAL, 20'h0BEEF, 20'h0BEEF);
    send_pair(1, FP_NEAR, 20'h00005, 20'h00006);
    send_pair(1, FP_EMPTY, 20'h00007, 20'h00007);

    configure(17'h1FFFF, 1'b1);
    send_pair(1, FP_RANDOM, 20'h00008, 20'h00009);
    send_pair(1, FP_DISJOINT, 20'h0000A, 20'h0000A);

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin thr = 17'h10000; excl = 1'b1; end
        1: begin thr = 17'h00000; excl = 1'b0; end
        2: begin thr = 17'h0FFFF; excl = 1'b0; end
        3: begin thr = 17'h1FFFF; excl = 1'b1; end
        default: begin
          thr  = DIST_W'($urandom_range(20000, 65536));
          excl = 1'($urandom_range(0, 1));
        end
      endcase
      if (p == 9) begin
        calm = 1'b1;
      end
      configure(thr, excl);
      target = words_sent + 100;
      while (words_sent < target) begin
        send_random_pair();
        if (p == 5 && words_sent >= target - 50 && words_sent < target - 40) begin
          // sender holds off until the block has returned every match
          wait_for_matches();
        end
      end
    end

    wait_for_matches();
    if (errors == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/jdtf_pkg.sv
rtl/core/jdtf_front.sv
rtl/core/jdtf_queue.sv
rtl/core/jdtf_back.sv
rtl/core/jaccard_distance_threshold_filter_top.sv
rtl/core/jdtf_checker.sv
sim/jdtf_match_checker.sv
sim/tb_top.sv
